### design/rmms_pkg.sv
// shared types, codes and pin tables for the relay matrix mode sequencer
package rmms_pkg;

  localparam int TickW = 10;

  typedef logic [TickW-1:0] ticks_t;

  // operation codes
  localparam logic [1:0] OP_SET_MODE = 2'd0;
  localparam logic [1:0] OP_ALL_OFF  = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_BUSY    = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_GAP       = 2'd0;
  localparam logic [1:0] CFG_DISCHARGE = 2'd1;
  localparam logic [1:0] CFG_SETTLE    = 2'd2;

  // reset values of the timing registers
  localparam ticks_t GAP_RESET       = 10'd5;
  localparam ticks_t DISCHARGE_RESET = 10'd20;
  localparam ticks_t SETTLE_RESET    = 10'd20;

  // modes, zero means every relay open
  localparam logic [2:0] MODE_OPEN = 3'd0;
  localparam logic [2:0] MODE_MAX  = 3'd4;

  // pin patterns
  localparam logic [7:0] PINS_OFF       = 8'h00;
  localparam logic [7:0] PINS_DISCHARGE = 8'hFC;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_GAP1   = 3'd1,
    PH_DISCH  = 3'd2,
    PH_GAP2   = 3'd3,
    PH_SETTLE = 3'd4
  } phase_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [2:0] mode;
  } req_t;

  typedef struct packed {
    logic [7:0] pin_state;
    logic [1:0] status;
    logic       busy_res;
    logic [2:0] current_mode;
    logic       done_res;
  } rsp_t;

  typedef struct packed {
    ticks_t gap_ticks;
    ticks_t discharge_ticks;
    ticks_t settle_ticks;
  } timing_t;

  // rows 0 and 1 plus column 0, plus one more column per mode
  function automatic logic [7:0] mode_pins(input logic [2:0] md);
    logic [7:0] p;
    case (md)
      3'd1:    p = 8'h1B;
      3'd2:    p = 8'h2B;
      3'd3:    p = 8'h4B;
      3'd4:    p = 8'h8B;
      default: p = PINS_OFF;
    endcase
    return p;
  endfunction

endpackage

### design/relay_matrix_mode_sequencer.sv
// top level of the relay matrix mode sequencer: request and response registers
//
// Sequences a 3-row by 5-column relay matrix through break-before-make mode
// changes. Requests carry a set-mode command, an all-off command or a one
// millisecond tick; every request yields exactly one response with the driven
// pin bitmap, a status code, the busy and done flags and the mode in force.
// A set-mode or all-off runs: all pins low for gap_ticks, then (if a mode was
// in force) discharge pins 0xFC for discharge_ticks and another gap, then (if
// the new mode is not none) the new mode's pins for settle_ticks. Each phase
// lasts exactly its register value in ticks, a value of 0 counting as 1.
// Throughput is one request per clock unless the response channel stalls;
// the request register feeds the sequencer, whose update loads the registered
// response. Both stages hold under response backpressure, so no request is
// dropped; an all-off with no mode in force finishes at once. Timing registers
// are written through the cfg port, which is always ready; index 3 is ignored.
module relay_matrix_mode_sequencer (
  input  logic               clk,
  input  logic               rst,
  // request channel
  input  logic               req_valid,
  output logic               req_ready,
  input  rmms_pkg::req_t     req,
  // response channel
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output rmms_pkg::rsp_t     rsp,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  rmms_pkg::ticks_t   cfg_data
);

  // request register
  rmms_pkg::req_t    req_q;
  logic              req_q_valid;
  // stage control
  logic              rsp_free;   // response register can take a new result
  logic              step;       // held request is processed this cycle
  rmms_pkg::timing_t timing;
  rmms_pkg::rsp_t    result;

  assign rsp_free  = !rsp_valid || rsp_ready;
  assign step      = req_q_valid && rsp_free;
  assign req_ready = !req_q_valid || rsp_free;
  assign cfg_ready = 1'b1;

  // request register, refilled in the same cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      req_q_valid <= 1'b0;
    end else if (req_ready) begin
      req_q_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready && req_valid) begin
      req_q <= req;
    end
  end

  rmms_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .timing   (timing)
  );

  // state machine advances once per processed request
  rmms_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .req    (req_q),
    .timing (timing),
    .result (result)
  );

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_free) begin
      rsp_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp <= result;
    end
  end

endmodule

### design/rmms_cfg_regs.sv
// timing configuration registers of the relay matrix mode sequencer
module rmms_cfg_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  rmms_pkg::ticks_t    wr_data,
  output rmms_pkg::timing_t   timing
);

  rmms_pkg::timing_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gap_ticks       <= rmms_pkg::GAP_RESET;
      regs.discharge_ticks <= rmms_pkg::DISCHARGE_RESET;
      regs.settle_ticks    <= rmms_pkg::SETTLE_RESET;
    end else if (wr_en) begin
      case (wr_index)
        rmms_pkg::CFG_GAP:       regs.gap_ticks       <= wr_data;
        rmms_pkg::CFG_DISCHARGE: regs.discharge_ticks <= wr_data;
        rmms_pkg::CFG_SETTLE:    regs.settle_ticks    <= wr_data;
        default: ;
      endcase
    end
  end

  assign timing = regs;

endmodule

### design/rmms_seq.sv
// switching state machine: phase, tick counter, mode and pin registers
module rmms_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  rmms_pkg::req_t    req,
  input  rmms_pkg::timing_t timing,
  output rmms_pkg::rsp_t    result
);

  rmms_pkg::phase_t phase, phase_next;
  rmms_pkg::ticks_t phase_counter, phase_counter_next;
  logic [2:0]       mode_in_force, mode_in_force_next;
  logic [2:0]       target_mode, target_mode_next;
  logic [7:0]       pins_driven, pins_driven_next;
  logic [1:0]       status;
  logic             done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= rmms_pkg::PH_IDLE;
      phase_counter <= '0;
      mode_in_force <= rmms_pkg::MODE_OPEN;
      target_mode   <= rmms_pkg::MODE_OPEN;
      pins_driven   <= rmms_pkg::PINS_OFF;
    end else if (step) begin
      phase         <= phase_next;
      phase_counter <= phase_counter_next;
      mode_in_force <= mode_in_force_next;
      target_mode   <= target_mode_next;
      pins_driven   <= pins_driven_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    phase_counter_next = phase_counter;
    mode_in_force_next = mode_in_force;
    target_mode_next   = target_mode;
    pins_driven_next   = pins_driven;
    status             = rmms_pkg::ST_OK;
    done               = 1'b0;

    case (req.operation)
      rmms_pkg::OP_SET_MODE, rmms_pkg::OP_ALL_OFF: begin
        if (phase != rmms_pkg::PH_IDLE) begin
          status = rmms_pkg::ST_BUSY;
        end else if (req.operation == rmms_pkg::OP_SET_MODE) begin
          if (req.mode > rmms_pkg::MODE_MAX) begin
            status = rmms_pkg::ST_INVALID;
          end else begin
            target_mode_next   = req.mode;
            phase_next         = rmms_pkg::PH_GAP1;
            phase_counter_next = timing.gap_ticks;
            pins_driven_next   = rmms_pkg::PINS_OFF;
          end
        end else if (mode_in_force != rmms_pkg::MODE_OPEN) begin
          target_mode_next   = rmms_pkg::MODE_OPEN;
          phase_next         = rmms_pkg::PH_GAP1;
          phase_counter_next = timing.gap_ticks;
          pins_driven_next   = rmms_pkg::PINS_OFF;
        end else begin
          // already open: finish on the spot
          pins_driven_next = rmms_pkg::PINS_OFF;
          target_mode_next = rmms_pkg::MODE_OPEN;
          done             = 1'b1;
        end
      end
      rmms_pkg::OP_TICK: begin
        if (phase != rmms_pkg::PH_IDLE) begin
          if (phase_counter <= rmms_pkg::ticks_t'(1)) begin
            // phase ran out, move on right away
            if (phase == rmms_pkg::PH_GAP1 && mode_in_force != rmms_pkg::MODE_OPEN) begin
              phase_next         = rmms_pkg::PH_DISCH;
              phase_counter_next = timing.discharge_ticks;
              pins_driven_next   = rmms_pkg::PINS_DISCHARGE;
            end else if (phase == rmms_pkg::PH_DISCH) begin
              phase_next         = rmms_pkg::PH_GAP2;
              phase_counter_next = timing.gap_ticks;
              pins_driven_next   = rmms_pkg::PINS_OFF;
            end else if ((phase == rmms_pkg::PH_GAP1 || phase == rmms_pkg::PH_GAP2)
                         && target_mode != rmms_pkg::MODE_OPEN) begin
              phase_next         = rmms_pkg::PH_SETTLE;
              phase_counter_next = timing.settle_ticks;
              pins_driven_next   = rmms_pkg::mode_pins(target_mode);
            end else begin
              mode_in_force_next = target_mode;
              phase_next         = rmms_pkg::PH_IDLE;
              phase_counter_next = '0;
              done               = 1'b1;
            end
          end else begin
            phase_counter_next = phase_counter - rmms_pkg::ticks_t'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    result.pin_state    = pins_driven_next;
    result.status       = status;
    result.busy_res     = (phase_next != rmms_pkg::PH_IDLE);
    result.current_mode = mode_in_force_next;
    result.done_res     = done;
  end

endmodule

### design/rmms_checker.sv
// port-level checks for the relay matrix mode sequencer, bound to the top level
module rmms_checker (
  input logic           clk,
  input logic           rst,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input rmms_pkg::rsp_t rsp
);

  // a held response stays put until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response dropped or changed while stalled");

  // completion leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.done_res |-> !rsp.busy_res && rsp.status == rmms_pkg::ST_OK)
    else $error("done reported with busy or error status");

  // mode in force is always a legal mode
  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.current_mode <= rmms_pkg::MODE_MAX)
    else $error("mode in force out of range");

  // idle in mode none means every relay is open
  a_none_open: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.busy_res && rsp.current_mode == rmms_pkg::MODE_OPEN
      |-> rsp.pin_state == rmms_pkg::PINS_OFF)
    else $error("pins driven while idle in mode none");

endmodule

bind relay_matrix_mode_sequencer rmms_checker u_rmms_checker (
  .clk       (clk),
  .rst       (rst),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);
